// ===== sv/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the smoothstep shuttle profile
// phase codes, fixed-point widths and the request/response bundles
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int TickW  = 8;
  localparam int HgtW   = 16;
  localparam int FracW  = 17;   // q0.16 plus one integer bit for exactly 1.0
  localparam int QuotW  = 16;
  localparam int CfgW   = 16;
  localparam int CfgIdxW = 2;

  localparam logic [FracW-1:0] QOne = 17'h10000;

  // cycle phase codes
  localparam logic [1:0] PH_BOTTOM = 2'd0;
  localparam logic [1:0] PH_RISE   = 2'd1;
  localparam logic [1:0] PH_TOP    = 2'd2;
  localparam logic [1:0] PH_FALL   = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TRAVEL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DWELL  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAXH   = 2'd2;

  // reset values of the registers
  localparam logic [TickW-1:0] TravelRst = 8'd120;
  localparam logic [TickW-1:0] DwellRst  = 8'd40;
  localparam logic [HgtW-1:0]  MaxHRst   = 16'd21130;

  typedef struct packed {
    logic             start;
    logic [TickW-1:0] num;
    logic [TickW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [FracW-1:0] x;
    logic [HgtW-1:0]  max_h;
  } poly_req_t;

  typedef struct packed {
    logic            done;
    logic [HgtW-1:0] height;
  } poly_rsp_t;

endpackage

// ===== sv/ssp_div.sv =====
// ----------------------------------------------------------------------------
// ssp_div: restoring fraction divider
// (num << 16) / den for num < den, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ssp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssp_pkg::div_req_t req_i,
  output ssp_pkg::div_rsp_t rsp_o
);
  import ssp_pkg::*;

  localparam int CntW = $clog2(QuotW);

  logic             run_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [TickW-1:0] rem_q;
  logic [TickW-1:0] den_q;
  logic [QuotW-1:0] quot_q;

  logic [TickW:0]   rem2;
  logic [TickW:0]   diff;
  logic             ge;

  assign rem2 = {rem_q, 1'b0};
  assign diff = rem2 - {1'b0, den_q};
  assign ge   = rem2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(QuotW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.num;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (run_q) begin
      rem_q  <= ge ? diff[TickW-1:0] : rem2[TickW-1:0];
      quot_q <= {quot_q[QuotW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== sv/ssp_poly.sv =====
// ----------------------------------------------------------------------------
// ssp_poly: quintic smoothstep and height scaling
// one shared multiplier stepped through x^2, x^3, x^3*p and max*s
// ----------------------------------------------------------------------------
module ssp_poly (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssp_pkg::poly_req_t req_i,
  output ssp_pkg::poly_rsp_t rsp_o
);
  import ssp_pkg::*;

  localparam int PW    = 21;           // width of 6*x2 + 10 - 15*x
  localparam int ProdW = PW + FracW;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_X2   = 3'd1;
  localparam logic [2:0] P_X3   = 3'd2;
  localparam logic [2:0] P_S    = 3'd3;
  localparam logic [2:0] P_H    = 3'd4;

  localparam logic [PW-1:0] TenQ = PW'(10 * 65536);

  logic [2:0]       step_q;
  logic             done_q;
  logic [FracW-1:0] x_q, x2_q, x3_q, s_q;
  logic [PW-1:0]    p_q;
  logic [HgtW-1:0]  max_q, height_q;

  logic [PW-1:0]    mul_a;
  logic [FracW-1:0] mul_b;
  logic [ProdW-1:0] prod;
  logic [PW-1:0]    p_pos, p_neg;
  logic [PW-1:0]    s_raw;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      P_X2:    begin mul_a = PW'(x_q);   mul_b = x_q;  end
      P_X3:    begin mul_a = PW'(x2_q);  mul_b = x_q;  end
      P_S:     begin mul_a = p_q;        mul_b = x3_q; end
      P_H:     begin mul_a = PW'(max_q); mul_b = s_q;  end
      default: begin mul_a = '0;         mul_b = '0;   end
    endcase
  end

  assign prod  = ProdW'(mul_a) * ProdW'(mul_b);
  assign p_pos = PW'(x2_q) * PW'(6) + TenQ;
  assign p_neg = PW'(x_q) * PW'(15);
  assign s_raw = prod[PW+15:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= P_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (step_q)
        P_IDLE:  if (req_i.start) step_q <= P_X2;
        P_X2:    step_q <= P_X3;
        P_X3:    step_q <= P_S;
        P_S:     step_q <= P_H;
        P_H:     begin
          step_q <= P_IDLE;
          done_q <= 1'b1;
        end
        default: step_q <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_q == P_IDLE && req_i.start) begin
      x_q   <= req_i.x;
      max_q <= req_i.max_h;
    end
    if (step_q == P_X2) x2_q <= prod[FracW+15:16];
    if (step_q == P_X3) begin
      x3_q <= prod[FracW+15:16];
      p_q  <= (p_pos >= p_neg) ? p_pos - p_neg : '0;
    end
    // clamp to 1.0
    if (step_q == P_S) s_q <= (s_raw > PW'(QOne)) ? QOne : s_raw[FracW-1:0];
    if (step_q == P_H) height_q <= prod[HgtW+15:16];
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.height = height_q;

endmodule

// ===== sv/smoothstep_shuttle_profile.sv =====
// ----------------------------------------------------------------------------
// smoothstep_shuttle_profile: quintic smoothstep shuttle profile generator
// four-phase cycle (bottom dwell, rise, top dwell, fall) advanced per tick
// ----------------------------------------------------------------------------
// flow: a hold beat or a dwell tick goes from accept straight to the done state;
//   a travel tick passes through the bit-serial fraction divider, then the
//   shared multiplier; it skips the divider when the fraction saturates
// throughput: one item at a time, in_stall_o stays high until the result is
//   loaded into the output register; the next beat may enter while it waits
// reset: phase bottom dwell, counter 40, height 0, registers 120/40/21130
module smoothstep_shuttle_profile (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [ssp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ssp_pkg::CfgW-1:0]    cfg_data_i,
  // tick channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        advance_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ssp_pkg::HgtW-1:0]    height_offset_o,
  output logic [1:0]                  phase_o,
  output logic                        phase_end_o
);
  import ssp_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_POLY = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_q;
  logic             adv_q;
  logic [1:0]       phase_q;
  logic [TickW-1:0] tick_q;
  logic [HgtW-1:0]  height_q;
  logic [HgtW-1:0]  calc_q;

  logic [TickW-1:0] travel_q, dwell_q;
  logic [HgtW-1:0]  maxh_q;

  logic             out_valid_q;
  logic [HgtW-1:0]  out_height_q;
  logic [1:0]       out_phase_q;
  logic             out_end_q;

  logic             in_acc, out_free;
  logic             travel_ph, sat;
  logic [TickW-1:0] num;

  ssp_pkg::div_req_t  div_req;
  ssp_pkg::div_rsp_t  div_rsp;
  ssp_pkg::poly_req_t poly_req;
  ssp_pkg::poly_rsp_t poly_rsp;

  // commit path
  logic [TickW-1:0] tick_dec;
  logic             ends;
  logic [1:0]       phase_nx;
  logic [TickW-1:0] tick_nx;
  logic [HgtW-1:0]  height_nx;
  logic             end_nx;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // rise and fall are the odd phases
  assign travel_ph = phase_q[0];

  // elapsed numerator: rising counts up from zero, falling counts down
  always_comb begin
    if (phase_q == PH_RISE) begin
      num = (tick_q < travel_q) ? travel_q - tick_q : '0;
    end else begin
      num = tick_q;
    end
  end

  // fraction at or above one (and zero travel length) clamps to 1.0
  assign sat = (num >= travel_q);

  assign div_req.start = in_acc && advance_i && travel_ph && !sat;
  assign div_req.num   = num;
  assign div_req.den   = travel_q;

  assign poly_req.start = (in_acc && advance_i && travel_ph && sat) ||
                          (state_q == S_DIV && div_rsp.done);
  assign poly_req.x     = (state_q == S_DIV) ? {1'b0, div_rsp.quot} : QOne;
  assign poly_req.max_h = maxh_q;

  ssp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ssp_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (poly_req),
    .rsp_o  (poly_rsp)
  );

  // tick down and phase advance, applied when the result is handed over
  always_comb begin
    tick_dec  = (tick_q != '0) ? tick_q - 1'b1 : '0;
    ends      = (tick_dec == '0);
    phase_nx  = phase_q;
    tick_nx   = tick_q;
    height_nx = height_q;
    end_nx    = 1'b0;
    if (adv_q) begin
      tick_nx = tick_dec;
      if (travel_ph) height_nx = calc_q;
      if (ends) begin
        phase_nx = phase_q + 2'd1;
        end_nx   = 1'b1;
        // odd next phase is a travel
        tick_nx  = phase_nx[0] ? travel_q : dwell_q;
        // snap to the endpoint at the end of a travel
        if (phase_q == PH_RISE) height_nx = maxh_q;
        if (phase_q == PH_FALL) height_nx = '0;
      end
    end
  end

  // sequencer and profile state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      adv_q       <= 1'b0;
      phase_q     <= PH_BOTTOM;
      tick_q      <= DwellRst;
      height_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new beat loads, else an accepted one leaves
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            adv_q <= advance_i;
            if (advance_i && travel_ph) begin
              state_q <= sat ? S_POLY : S_DIV;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) state_q <= S_POLY;
        end
        S_POLY: begin
          if (poly_rsp.done) state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            phase_q  <= phase_nx;
            tick_q   <= tick_nx;
            height_q <= height_nx;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // travel height result
  always_ff @(posedge clk_i) begin
    if (state_q == S_POLY && poly_rsp.done) calc_q <= poly_rsp.height;
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_height_q <= height_nx;
      out_phase_q  <= phase_nx;
      out_end_q    <= end_nx;
    end
  end

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      travel_q <= TravelRst;
      dwell_q  <= DwellRst;
      maxh_q   <= MaxHRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TRAVEL: travel_q <= cfg_data_i[TickW-1:0];
        CFG_DWELL:  dwell_q  <= cfg_data_i[TickW-1:0];
        CFG_MAXH:   maxh_q   <= cfg_data_i[HgtW-1:0];
        default:    ;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign height_offset_o = out_height_q;
  assign phase_o         = out_phase_q;
  assign phase_end_o     = out_end_q;

endmodule

// ===== sv/ssp_chk.sv =====
// ----------------------------------------------------------------------------
// ssp_chk: port-level checks for the smoothstep shuttle profile
// watches handshakes and profile invariants, bound to the top level
// ----------------------------------------------------------------------------
module ssp_chk (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [ssp_pkg::HgtW-1:0] height_offset_o,
  input logic [1:0]               phase_o,
  input logic                     phase_end_o
);
  import ssp_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(height_offset_o) && $stable(phase_o) &&
      $stable(phase_end_o))
    else $error("stalled result beat changed");

  // an accepted beat keeps the block busy the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("not busy after accepting a beat");

  // a new result only follows an item in flight
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no item in flight");

  // bottom dwell always sits at home
  a_bottom_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_o == PH_BOTTOM |-> height_offset_o == '0)
    else $error("nonzero height in bottom dwell");

endmodule

bind smoothstep_shuttle_profile ssp_chk u_ssp_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .height_offset_o (height_offset_o),
  .phase_o         (phase_o),
  .phase_end_o     (phase_end_o)
);
